>>> rtl/core/cffa_pkg.sv
// Shared types and constants for the contiguous first-fit allocator.
// Used by cffa_chain and the top level; depends on nothing else.
package cffa_pkg;

    // Field widths of the stream and configuration beats.
    localparam int IDX_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int POS_W      = 7;
    localparam int CFG_W      = 7;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Defaults handed to the top level.
    localparam int DEF_NUM_BLOCKS    = 64;
    localparam int DEF_BLOCKS_IN_USE = 64;

    // Input beat kinds carried in s_tuser.
    localparam logic FUNC_RELEASE  = 1'b0;
    localparam logic FUNC_ALLOCATE = 1'b1;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic rel_en;   // release the block selected by the index
        logic inject;   // scan token enters cell zero
        logic scan_on;  // cells holding the token evaluate it
        logic drop;     // forget pending blocks of a broken run
        logic commit;   // mark all pending blocks used
    } chain_ctrl_t;

    // Summary of the row returned to the sequencer.
    typedef struct packed {
        logic hit;        // a run reached the requested size this cycle
        logic used_seen;  // the token sat on a used block this cycle
        logic any_free;   // a managed block is free
    } chain_stat_t;

endpackage

>>> rtl/core/cffa_cell.sv
// One block of the free map: its free bit, a pending mark and a scan stage.
// Depends on cffa_pkg only through its parent; uses no package items itself.
module cffa_cell #(
    parameter int RUN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tok_in,
    input  logic [RUN_W-1:0] run_in,
    input  logic [RUN_W-1:0] size,
    input  logic             scan_on,
    input  logic             drop,
    input  logic             commit,
    input  logic             set_free,
    output logic             tok_out,
    output logic [RUN_W-1:0] run_out,
    output logic             free,
    output logic             hit,
    output logic             used
);

    logic             tok_reg, tok_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             free_reg, free_next;
    logic             pend_reg, pend_next;
    logic             active;

    // Evaluate the token: extend or restart the run of free blocks.
    always_comb begin
        active    = tok_in & scan_on;
        run_next  = free_reg ? run_in + RUN_W'(1) : '0;
        hit       = active & free_reg & (run_next == size);
        used      = active & ~free_reg;
        tok_next  = active;
    end

    // A free block seen by the scan stays pending until its run breaks or wins.
    always_comb begin
        pend_next = pend_reg;
        priority if (commit) begin
            pend_next = 1'b0;
        end else if (active & free_reg) begin
            pend_next = 1'b1;
        end else if (drop) begin
            pend_next = 1'b0;
        end
    end

    // Release sets the bit; a commit clears it when the block is pending.
    always_comb begin
        free_next = free_reg;
        priority if (set_free) begin
            free_next = 1'b1;
        end else if (commit & pend_reg) begin
            free_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg  <= 1'b0;
            free_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            tok_reg  <= tok_next;
            free_reg <= free_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_reg <= run_next;
    end

    assign tok_out = tok_reg;
    assign run_out = run_reg;
    assign free    = free_reg;

endmodule

>>> rtl/core/cffa_chain.sv
// Row of cffa_cell instances that hands the scan token and run length along.
// Depends on cffa_pkg for the control and status structs and on cffa_cell.
module cffa_chain #(
    parameter int NUM_BLOCKS = cffa_pkg::DEF_NUM_BLOCKS,
    parameter int RUN_W      = $clog2(NUM_BLOCKS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cffa_pkg::chain_ctrl_t        ctrl,
    input  logic [cffa_pkg::IDX_W-1:0]   rel_idx,
    input  logic [RUN_W-1:0]             n_eff,
    input  logic [RUN_W-1:0]             size,
    output cffa_pkg::chain_stat_t        stat
);

    localparam int XW = (cffa_pkg::IDX_W > RUN_W) ? cffa_pkg::IDX_W : RUN_W;

    logic [NUM_BLOCKS:0]  tok_link;
    logic [RUN_W-1:0]     run_link [NUM_BLOCKS+1];
    logic [NUM_BLOCKS-1:0] free_vec, hit_vec, used_vec, set_vec, managed_vec;
    logic [XW-1:0]        idx_ext, n_ext;

    assign idx_ext     = XW'(rel_idx);
    assign n_ext       = XW'(n_eff);
    assign tok_link[0] = ctrl.inject;
    assign run_link[0] = '0;

    for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
        // Release decode and the managed range for this block.
        assign set_vec[i]     = ctrl.rel_en & (idx_ext == XW'(i));
        assign managed_vec[i] = (XW'(i) < n_ext);

        cffa_cell #(
            .RUN_W (RUN_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .tok_in   (tok_link[i]),
            .run_in   (run_link[i]),
            .size     (size),
            .scan_on  (ctrl.scan_on),
            .drop     (ctrl.drop),
            .commit   (ctrl.commit),
            .set_free (set_vec[i]),
            .tok_out  (tok_link[i+1]),
            .run_out  (run_link[i+1]),
            .free     (free_vec[i]),
            .hit      (hit_vec[i]),
            .used     (used_vec[i])
        );
    end

    // Reduce the row to a few status bits for the sequencer.
    always_comb begin
        stat.hit       = |hit_vec;
        stat.used_seen = |used_vec;
        stat.any_free  = |(free_vec & managed_vec);
    end

endmodule

>>> rtl/core/contiguous_first_fit_allocator.sv
// Top level of the contiguous first-fit allocator: stream ports, sequencer,
// result register. Depends on cffa_pkg, cffa_chain and cffa_cell.
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_*       in         tdata: block_index[5:0], request_size[12:6]; tuser: func
//  m_*       out        tdata: run_start[6:0], run_end[13:7], space_left[14];
//                       tuser: granted
//  cfg_*     in         cfg_data: blocks_in_use[6:0]
//
// A release goes from accept straight to the result state. An allocation
// walks the token along the managed cell row one block per cycle, then passes
// through a commit state if a run was found, then the result state. Failed
// size checks also go straight to the result state. Reset marks every block
// used and sets blocks_in_use to 64. A stalled result holds in the output register
// while the next beat is already accepted; that beat then waits in its result state.
module contiguous_first_fit_allocator #(
    parameter int NUM_BLOCKS = cffa_pkg::DEF_NUM_BLOCKS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cffa_pkg::S_TDATA_W-1:0]   s_tdata,  // block_index, request_size
    input  logic                             s_tuser,  // func
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cffa_pkg::M_TDATA_W-1:0]   m_tdata,  // run_start, run_end, space_left
    output logic                             m_tuser,  // granted
    // Configuration write.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cffa_pkg::CFG_W-1:0]       cfg_data
);

    localparam int RUN_W = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W = $clog2(NUM_BLOCKS);
    localparam int CW    = (RUN_W > cffa_pkg::SIZE_W) ? RUN_W : cffa_pkg::SIZE_W;
    localparam int POS_W = cffa_pkg::POS_W;
    localparam int IDX_W = cffa_pkg::IDX_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    inj_reg, inj_next;
    logic                    drop_reg, drop_next;
    logic [CW-1:0]           size_reg, size_next;
    logic                    gr_reg, gr_next;
    logic [POS_W-1:0]        start_reg, start_next;
    logic [POS_W-1:0]        end_reg, end_next;
    logic [cffa_pkg::CFG_W-1:0] biu_reg;
    logic                    mv_reg, mv_next;
    logic [cffa_pkg::M_TDATA_W-1:0] md_reg, md_next;
    logic                    mu_reg, mu_next;

    logic                    s_acc, func;
    logic [IDX_W-1:0]        in_idx;
    logic [cffa_pkg::SIZE_W-1:0] in_size;
    logic [CW-1:0]           biu_ext, in_size_ext, n_cw, cnt_cw, end_val, start_val;
    logic [RUN_W-1:0]        n_eff;
    logic                    last_cell, out_free;
    cffa_pkg::chain_ctrl_t   ctrl;
    cffa_pkg::chain_stat_t   stat;

    // Unpack the input beat and clamp the block count.
    always_comb begin
        func        = s_tuser;
        in_idx      = s_tdata[IDX_W-1:0];
        in_size     = s_tdata[IDX_W +: cffa_pkg::SIZE_W];
        in_size_ext = CW'(in_size);
        biu_ext     = CW'(biu_reg);
        n_cw        = (biu_ext > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : biu_ext;
        n_eff       = n_cw[RUN_W-1:0];
        cnt_cw      = CW'(cnt_reg);
        last_cell   = ((cnt_cw + CW'(1)) == n_cw);
        end_val     = cnt_cw + CW'(1);
        start_val   = end_val - size_reg + CW'(1);
        s_acc       = s_tvalid & s_tready;
        out_free    = ~mv_reg | m_tready;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Controls broadcast to the cell row.
    always_comb begin
        ctrl.rel_en  = s_acc & (func == cffa_pkg::FUNC_RELEASE)
                       & ((CW'(in_idx)) < n_cw);
        ctrl.inject  = inj_reg;
        ctrl.scan_on = (state_reg == ST_SCAN);
        ctrl.drop    = drop_reg;
        ctrl.commit  = (state_reg == ST_COMMIT);
    end

    cffa_chain #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .RUN_W      (RUN_W)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .rel_idx (in_idx),
        .n_eff   (n_eff),
        .size    (size_reg[RUN_W-1:0]),
        .stat    (stat)
    );

    // Sequencer: accept, walk the token, commit a found run, deliver.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        inj_next   = 1'b0;
        drop_next  = 1'b0;
        size_next  = size_reg;
        gr_next    = gr_reg;
        start_next = start_reg;
        end_next   = end_reg;
        mv_next    = mv_reg & ~m_tready;
        md_next    = md_reg;
        mu_next    = mu_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    size_next  = in_size_ext;
                    gr_next    = 1'b0;
                    start_next = '0;
                    end_next   = '0;
                    cnt_next   = '0;
                    if ((func == cffa_pkg::FUNC_ALLOCATE) && (in_size_ext != '0)
                        && (in_size_ext <= n_cw)) begin
                        inj_next   = 1'b1;
                        drop_next  = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                drop_next = stat.used_seen;
                if (stat.hit) begin
                    gr_next    = 1'b1;
                    start_next = start_val[POS_W-1:0];
                    end_next   = end_val[POS_W-1:0];
                    state_next = ST_COMMIT;
                end else if (last_cell) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_COMMIT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    md_next    = cffa_pkg::M_TDATA_W'({stat.any_free, end_reg, start_reg});
                    mu_next    = gr_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            inj_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            biu_reg   <= cffa_pkg::CFG_W'(cffa_pkg::DEF_BLOCKS_IN_USE);
        end else begin
            state_reg <= state_next;
            inj_reg   <= inj_next;
            drop_reg  <= drop_next;
            mv_reg    <= mv_next;
            if (cfg_valid & cfg_ready) begin
                biu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        size_reg  <= size_next;
        gr_reg    <= gr_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    // A commit always follows a scan cycle that found a run.
    a_commit_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT) |-> ($past(state_reg) == ST_SCAN && $past(stat.hit)))
        else $error("commit without a found run");

    // A run is only found while the token is walking.
    a_hit_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.hit |-> (state_reg == ST_SCAN))
        else $error("run found outside a scan");

    // A granted result names a nonzero start no later than its end.
    a_grant_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && NUM_BLOCKS < 128) |->
            (m_tdata[POS_W-1:0] != '0 && m_tdata[POS_W-1:0] <= m_tdata[2*POS_W-1:POS_W]))
        else $error("granted run has a bad range");

endmodule

>>> bench/tb.sv
// Self-checking testbench for contiguous_first_fit_allocator: it drives release
// and allocate beats, predicts every result beat from its own free-block map and
// compares them field by field. Depends on cffa_pkg and the allocator RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB        = cffa_pkg::DEF_NUM_BLOCKS;
    localparam int IDX_W     = cffa_pkg::IDX_W;
    localparam int SIZE_W    = cffa_pkg::SIZE_W;
    localparam int POS_W     = cffa_pkg::POS_W;
    localparam int CFG_W     = cffa_pkg::CFG_W;
    localparam int S_TDATA_W = cffa_pkg::S_TDATA_W;
    localparam int M_TDATA_W = cffa_pkg::M_TDATA_W;
    localparam int LIMIT_NS  = 20_000_000;

    // One predicted or observed result beat.
    typedef struct packed {
        logic             granted;
        logic [POS_W-1:0] run_start;
        logic [POS_W-1:0] run_end;
        logic             space_left;
    } alloc_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;  // block_index[5:0], request_size[12:6]
    logic                 s_tuser   = cffa_pkg::FUNC_RELEASE;  // func
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // run_start[6:0], run_end[13:7], space_left[14]
    logic                 m_tuser;  // granted
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Predictor state: free map (1 = free) and the block count register.
    logic [NB-1:0]        free_blocks = '0;
    logic [CFG_W-1:0]     managed_cfg = CFG_W'(cffa_pkg::DEF_BLOCKS_IN_USE);
    alloc_result_t        pending_q[$];
    alloc_result_t        head_expect;

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int freeze_left    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int grants_seen    = 0;
    int fail_count     = 0;
    int configs_done   = 0;
    int input_stalls   = 0;

    contiguous_first_fit_allocator #(
        .NUM_BLOCKS(NB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Applies one beat to the predicted free map and returns the expected result.
    function automatic alloc_result_t predict_outcome(input logic func,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [SIZE_W-1:0] size);
        alloc_result_t r;
        int n;
        int run;
        int lo;
        r = '0;
        n = (managed_cfg > NB) ? NB : int'(managed_cfg);
        run = 0;
        if (func == cffa_pkg::FUNC_RELEASE) begin
            if (idx < n) free_blocks[idx] = 1'b1;
        end else if (size != 0 && size <= n) begin
            // First fit: stop at the first run that reaches the requested size.
            for (int i = 0; i < n && !r.granted; i++) begin
                run = free_blocks[i] ? run + 1 : 0;
                if (run == int'(size)) begin
                    lo = i + 1 - int'(size);
                    for (int k = lo; k <= i; k++) free_blocks[k] = 1'b0;
                    r.granted   = 1'b1;
                    r.run_start = POS_W'(lo + 1);
                    r.run_end   = POS_W'(i + 1);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            if (free_blocks[i]) r.space_left = 1'b1;
        end
        return r;
    endfunction

    // Counts a failure; only the first ten are printed.
    function void report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void check_field(input string name, input int want, input int got);
        if (want != got)
            report_failure($sformatf("result %0d, %s: expected %0d, got %0d",
                                     results_seen, name, want, got));
    endfunction

    // Receiver: random stalls, or a long hold-off while freeze_left runs down.
    always @(posedge aclk) begin
        if (freeze_left > 0) begin
            m_tready    <= 1'b0;
            freeze_left <= freeze_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Count cycles in which the block refuses an offered input beat.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready) input_stalls++;
    end

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser) grants_seen++;
            if (pending_q.size() == 0) begin
                report_failure($sformatf("result %0d arrived with nothing pending: %h/%b",
                                         results_seen, m_tdata, m_tuser));
            end else begin
                head_expect = pending_q.pop_front();
                check_field("granted",    head_expect.granted,    m_tuser);
                check_field("run_start",  head_expect.run_start,  m_tdata[6:0]);
                check_field("run_end",    head_expect.run_end,    m_tdata[13:7]);
                check_field("space_left", head_expect.space_left, m_tdata[14]);
            end
        end
    end

    // Sends one beat after an optional random gap; returns right after the accept.
    task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                             input logic [SIZE_W-1:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {3'b000, size, idx};
        do @(posedge aclk); while (!s_tready);
        pending_q.push_back(predict_outcome(func, idx, size));
        items_sent++;
    endtask

    // Stops offering beats and waits until every predicted result has arrived.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes the block count register once the block has gone quiet.
    task automatic set_block_count(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        managed_cfg = value;
        configs_done++;
    endtask

    // Right after reset every block is used: allocations fail until blocks are released.
    task automatic test_empty_device();
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd1);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd63, 7'd0);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd64);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd127);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd0,  7'd127);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd0,  7'd0);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd63, 7'd0);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd1);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd1);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd1);
    endtask

    // Short runs ahead of a longer one must be skipped.
    task automatic test_first_fit();
        send_item(cffa_pkg::FUNC_RELEASE,  6'd3,  7'd0);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd5,  7'd0);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd6,  7'd0);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd10, 7'd0);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd11, 7'd0);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd12, 7'd0);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd2);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd3);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd1);
    endtask

    // Smallest, zero and oversized block counts; the free map survives each change.
    task automatic test_register_extremes();
        set_block_count(7'd1);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd1,  7'd0);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd0,  7'd0);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd2);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd1);
        set_block_count(7'd0);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd0,  7'd0);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd1);
        set_block_count(7'd127);
        send_item(cffa_pkg::FUNC_RELEASE,  6'd63, 7'd0);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0,  7'd1);
    endtask

    // Free the whole device and take it back in one allocation.
    task automatic test_whole_device();
        set_block_count(7'd64);
        send_idle_pct = 25;
        stall_pct     = 25;
        for (int i = 0; i < NB; i++)
            send_item(cffa_pkg::FUNC_RELEASE, IDX_W'(i), 7'($urandom_range(127)));
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0, 7'd64);
        send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0, 7'd1);
    endtask

    // Mostly release bursts followed by fitting allocations, with some noise.
    task automatic test_random_mix(input int idle, input int stall,
                                   input logic [CFG_W-1:0] count_cfg, input int items);
        int n;
        int pick;
        int start;
        int len;
        int target;
        set_block_count(count_cfg);
        send_idle_pct = idle;
        stall_pct     = stall;
        n = (count_cfg > NB) ? NB : int'(count_cfg);
        target = items_sent + items;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (n == 0 || pick < 10) begin
                send_item(cffa_pkg::FUNC_RELEASE, 6'($urandom_range(63)),
                          7'($urandom_range(127)));
            end else if (pick < 50) begin
                start = $urandom_range(n - 1);
                len   = $urandom_range(1, 8);
                for (int j = 0; j < len && start + j < NB; j++)
                    send_item(cffa_pkg::FUNC_RELEASE, IDX_W'(start + j),
                              7'($urandom_range(127)));
            end else if (pick < 60) begin
                send_item(cffa_pkg::FUNC_ALLOCATE, 6'($urandom_range(63)),
                          7'($urandom_range(127)));
            end else if ($urandom_range(4) == 0) begin
                send_item(cffa_pkg::FUNC_ALLOCATE, 6'($urandom_range(63)),
                          7'($urandom_range(1, n)));
            end else begin
                send_item(cffa_pkg::FUNC_ALLOCATE, 6'($urandom_range(63)),
                          7'($urandom_range(1, (n < 8) ? n : 8)));
            end
        end
    endtask

    // The receiver holds off for a long stretch while beats keep coming.
    task automatic test_backpressure();
        set_block_count(7'd64);
        send_idle_pct = 0;
        stall_pct     = 0;
        freeze_left <= 400;
        for (int i = 0; i < 60; i++) begin
            if (i % 3 == 2)
                send_item(cffa_pkg::FUNC_ALLOCATE, 6'd0, 7'($urandom_range(1, 3)));
            else
                send_item(cffa_pkg::FUNC_RELEASE, 6'($urandom_range(63)), 7'd0);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_device();
        test_first_fit();
        test_register_extremes();
        test_whole_device();
        test_random_mix(0,  0,  7'd64,  200);
        test_random_mix(45, 0,  7'd12,  200);
        test_random_mix(0,  45, 7'd127, 200);
        test_random_mix(25, 25, 7'd1,   150);
        test_random_mix(45, 0,  7'd32,  200);
        test_random_mix(25, 25, 7'($urandom_range(2, 64)), 200);
        test_random_mix(0,  0,  7'd0,   40);
        test_backpressure();

        // Let the last allocation scan finish before the final verdict.
        wait_idle();
        repeat (80) @(posedge aclk);
        fail_count += pending_q.size();

        $display("Ran %0d input beats, %0d result beats (%0d grants), %0d block-count writes.",
                 items_sent, results_seen, grants_seen, configs_done);
        $display("Input was stalled for %0d cycles under receiver back-pressure and scans.",
                 input_stalls);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
